// ===== rtl/lcg_ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// lcg_ssd_pkg
// Shared types, constants and the salt table for the salted stream decrypter
// ----------------------------------------------------------------------------
package lcg_ssd_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  count_t;

  localparam word_t  LCG_MUL = 32'd1103515245;
  localparam word_t  LCG_ADD = 32'h0000_3039;

  localparam count_t COUNT_RESET  = 3'd1;
  localparam count_t COUNT_RELOAD = 3'd4;
  localparam byte_t  PREV_RESET   = 8'hFF;

  // control from the input stage to the key schedule
  typedef struct packed {
    logic step;
    logic restart;
  } core_ctl_t;

  localparam word_t SALT_WORDS [64] = '{
    32'h1E0D8064, 32'h16EFF6E2, 32'h3A29FF98, 32'hAD28CF5E, 32'hCEFC4584, 32'hACE3AB65,
    32'h924997EB, 32'hF7A813C3, 32'hDED07CDD, 32'hEC7278F8, 32'h2B9412A5, 32'h909A5339,
    32'h99AE3F04, 32'hC1BF7532, 32'hFEDB9102, 32'hF0B5D67D, 32'hB6B33C3D, 32'hA276BC00,
    32'h8550E19C, 32'h2D664A09, 32'h79D56AB7, 32'hD11B3EEA, 32'h95717BA3, 32'h8B87B259,
    32'h18819F5C, 32'h934BCB27, 32'hBD6B2A11, 32'h19F5C8A0, 32'h40C21FF2, 32'hDA03DF6C,
    32'h82B15521, 32'hE6778963, 32'h2473C9A9, 32'h37E4D9C6, 32'h68F44F17, 32'hAF8607C7,
    32'hDCB8A6FA, 32'h8E470A88, 32'h831A14E7, 32'h7F359E74, 32'hA1E052FD, 32'h330B4C41,
    32'hBBF38F44, 32'h0C7A5808, 32'h9BE53BF1, 32'hC05DD426, 32'h60A77EF9, 32'h342551E8,
    32'h5A4D0FD7, 32'hC41D36D3, 32'h62202F8A, 32'h8D61AAB0, 32'h4801698C, 32'h6ED8ED38,
    32'h2E05CC42, 32'h065B1022, 32'h0E46234E, 32'hEE5FE9BA, 32'hA430B4B9, 32'h571CBE54,
    32'h9D96FBCD, 32'h70C56731, 32'h566D4315, 32'hCA6FD22C
  };

  // words are stored little-endian: byte 0 of a word is its low byte
  function automatic byte_t salt_byte(input byte_t idx);
    word_t w;
    byte_t b;
    w = SALT_WORDS[idx[7:2]];
    unique case (idx[1:0])
      2'd0:    b = w[7:0];
      2'd1:    b = w[15:8];
      2'd2:    b = w[23:16];
      default: b = w[31:24];
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/lcg_salted_stream_decrypt_top.sv =====
// ----------------------------------------------------------------------------
// lcg_salted_stream_decrypt_top
// Salted byte-stream decrypter with a chained salt lookup and LCG key stream
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid/in_ready carry cipher_byte and restart, one byte
//                 per transaction; restart reseeds the key stream first
//   out channel : out_valid/out_ready carry plain_byte, one per input byte,
//                 in input order
//   cfg channel : cfg_valid/cfg_ready write cfg_data into the seed register;
//                 cfg_ready is always high, write only while the block is idle
// Pipeline: input register, then result register. Throughput: one byte per
//   cycle while the output is not stalled by out_ready; the key schedule
//   multiply and the salt table lookup both lie between the input register
//   and the result register.
// Reset (rst, synchronous): both stages empty, seed 0, key stream state as
//   after a restart with seed 0.
// Stall: while out_valid is high and out_ready low the result holds, the
//   input register keeps its byte and in_ready drops once it is full.
// ----------------------------------------------------------------------------
module lcg_salted_stream_decrypt_top import lcg_ssd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  cipher_byte,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  plain_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  word_t     seed;
  logic      s1_valid;
  byte_t     s1_cipher;
  logic      s1_restart;
  logic      s1_adv;
  core_ctl_t ctl;
  byte_t     result_next;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_valid && cfg_ready) begin
      seed <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cipher  <= cipher_byte;
      s1_restart <= restart;
    end
  end

  assign ctl.step    = s1_adv;
  assign ctl.restart = s1_restart;

  lcg_ssd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cipher_byte (s1_cipher),
    .seed        (seed),
    .plain_byte  (result_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      plain_byte <= result_next;
    end
  end

  a_ready_low_full : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid)
    else $error("in_ready low with empty input register");

  a_stall_holds_s1 : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> s1_valid)
    else $error("input register lost its byte during a stall");

  a_adv_gives_result : assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("advanced byte did not reach the result register");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("stages not empty after reset");

endmodule

// ===== rtl/lcg_ssd_core.sv =====
// ----------------------------------------------------------------------------
// lcg_ssd_core
// Key schedule, chaining state and salt lookup for one byte per cycle while ctl.step is high
// ----------------------------------------------------------------------------
module lcg_ssd_core import lcg_ssd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  core_ctl_t ctl,
  input  byte_t     cipher_byte,
  input  word_t     seed,
  output byte_t     plain_byte
);

  word_t  lcg_state, lcg_state_next;
  word_t  key_word, key_word_next;
  count_t byte_count, byte_count_next;
  byte_t  previous_byte;

  word_t       eff_state;
  word_t       eff_key;
  count_t      eff_count;
  byte_t       eff_prev;
  count_t      count_dec;
  logic        reload;
  word_t       product;
  word_t       lcg_step;

  always_comb begin
    // a restart reseeds the state before this byte is used
    eff_state = ctl.restart ? seed : lcg_state;
    eff_key   = ctl.restart ? '0 : key_word;
    eff_count = ctl.restart ? COUNT_RESET : byte_count;
    eff_prev  = ctl.restart ? ~seed[7:0] : previous_byte;

    count_dec = eff_count - 3'd1;
    reload    = (count_dec == '0);
    // only the low word of the product is kept, mod 2^32
    product   = eff_state * LCG_MUL;
    lcg_step  = product + LCG_ADD;

    lcg_state_next  = reload ? lcg_step : eff_state;
    key_word_next   = reload ? lcg_step : (eff_key >> 8);
    byte_count_next = reload ? COUNT_RELOAD : count_dec;

    plain_byte = salt_byte(cipher_byte ^ eff_prev) ^ key_word_next[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state     <= '0;
      key_word      <= '0;
      byte_count    <= COUNT_RESET;
      previous_byte <= PREV_RESET;
    end else if (ctl.step) begin
      lcg_state     <= lcg_state_next;
      key_word      <= key_word_next;
      byte_count    <= byte_count_next;
      previous_byte <= cipher_byte;
    end
  end

endmodule

// ===== tb/sv/tb_lcg_salted_stream_decrypt_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lcg_salted_stream_decrypt_top
// Self-checking bench for the salted stream decrypter: a clocked driver feeds
// cipher bytes from a queue, a local key-schedule model predicts each plain
// byte on acceptance, and a clocked monitor checks results in order under
// several sender and receiver idling mixes and seed settings
// ----------------------------------------------------------------------------
module tb_lcg_salted_stream_decrypt_top;
  import lcg_ssd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SEGMENT_LEN = 125;

  typedef struct {
    byte_t cipher;
    logic  restart;
  } cipher_item_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  cipher_byte;
  logic        restart;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  plain_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  cipher_item_t cipher_q[$];
  byte_t        plain_due_q[$];
  byte_t        plain_wanted;

  // local copy of the key schedule
  word_t  seed_copy;
  word_t  key_lcg;
  word_t  key_shift;
  count_t key_phase;
  byte_t  chain_byte;

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int cycle_count;

  lcg_salted_stream_decrypt_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cipher_byte (cipher_byte),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .plain_byte  (plain_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic byte_t decrypt_next_byte(input byte_t c, input logic rs);
    byte_t idx;
    word_t w;
    if (rs) begin
      key_lcg    = seed_copy;
      key_shift  = '0;
      key_phase  = COUNT_RESET;
      chain_byte = ~seed_copy[7:0];
    end
    key_phase = key_phase - 3'd1;
    if (key_phase == 3'd0) begin
      key_phase = COUNT_RELOAD;
      key_lcg   = key_lcg * LCG_MUL + LCG_ADD;
      key_shift = key_lcg;
    end else begin
      key_shift = key_shift >> 8;
    end
    idx        = c ^ chain_byte;
    chain_byte = c;
    w          = SALT_WORDS[idx[7:2]];
    return w[8*idx[1:0] +: 8] ^ key_shift[7:0];
  endfunction

  // driver: predicts on each accepted transaction, then offers the next byte
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        plain_due_q.push_back(decrypt_next_byte(cipher_byte, restart));
        cipher_q.pop_front();
      end
      if (!in_valid || in_ready) begin
        if (cipher_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid    <= 1'b1;
          cipher_byte <= cipher_q[0].cipher;
          restart     <= cipher_q[0].restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (plain_due_q.size() == 0) begin
          $display("%0t: unexpected plain_byte, expected none, got %02h", $time, plain_byte);
          error_count++;
        end else begin
          plain_wanted = plain_due_q.pop_front();
          if (plain_byte !== plain_wanted) begin
            $display("%0t: plain_byte mismatch, expected %02h, got %02h",
                     $time, plain_wanted, plain_byte);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[lcg_salted_stream_decrypt_top] ERROR");
      $finish;
    end
  end

  task automatic queue_byte(input byte_t c, input logic rs);
    cipher_item_t item;
    item.cipher  = c;
    item.restart = rs;
    cipher_q.push_back(item);
  endtask

  // buffers of random length, each opened by a restart, with stray restarts; a stream may begin part way into a buffer
  task automatic queue_stream(input int count);
    int left;
    logic rs;
    left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        left = $urandom_range(1, 48);
        rs   = 1'b1;
      end else begin
        rs = ($urandom_range(0, 99) < 3);
      end
      left--;
      queue_byte(byte_t'($urandom_range(0, 255)), rs);
    end
  endtask

  task automatic wait_idle();
    while (cipher_q.size() != 0 || plain_due_q.size() != 0 || in_valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_seed(input word_t value);
    bit done;
    done = 1'b0;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    while (!done) begin
      @(posedge clk);
      if (cfg_ready) begin
        done      = 1'b1;
        seed_copy = value;
        cfg_valid <= 1'b0;
      end
    end
  endtask

  initial begin
    word_t seed;
    rst           = 1'b1;
    in_valid      = 1'b0;
    cipher_byte   = '0;
    restart       = 1'b0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    error_count   = 0;
    cycle_count   = 0;
    seed_copy     = '0;
    key_lcg       = '0;
    key_shift     = '0;
    key_phase     = COUNT_RESET;
    chain_byte    = PREV_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // no restart after reset: stream runs as if seeded with zero
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    wait_idle();

    // all-ones seed, restarts back to back and part way through a key word
    write_seed(32'hFFFF_FFFF);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'h01, 1'b1);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hFE, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'hA5, 1'b1);
    wait_idle();

    write_seed(32'h0000_0000);
    queue_byte(8'h12, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'h3C, 1'b0);
    queue_byte(8'h00, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      for (int seg = 0; seg < 3; seg++) begin
        wait_idle();
        case (phase)
          0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
          1: begin send_idle_pct = 57; recv_idle_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_idle_pct = 57; end
          default: begin send_idle_pct = 14; recv_idle_pct = 14; end
        endcase
        case ((phase * 3 + seg) % 4)
          0: seed = $urandom;
          1: seed = 32'h0000_0000;
          2: seed = 32'hFFFF_FFFF;
          default: seed = {$urandom_range(0, 1) ? 8'h80 : 8'h7F, 24'($urandom)};
        endcase
        write_seed(seed);
        queue_stream(SEGMENT_LEN);
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (error_count == 0 && plain_due_q.size() == 0) begin
      $display("[lcg_salted_stream_decrypt_top] OK");
    end else begin
      $display("[lcg_salted_stream_decrypt_top] ERROR");
    end
    $finish;
  end

endmodule
